>>> hw/rtl/tekp_pkg.sv
// shared types, codes and constants of the terminal escape key parser
// no dependencies
package tekp_pkg;

    localparam int MAX_SEQ_BYTES = 256;
    localparam int CNT_W         = $clog2(MAX_SEQ_BYTES + 1);
    localparam int KEY_VALUE_W   = 17;
    localparam int KEY_TYPE_W    = 3;
    localparam int PARAM_W       = 16;
    localparam int PROD_W        = PARAM_W + 4;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_NEXT  = 2'd1;

    localparam logic [KEY_TYPE_W-1:0] KT_INVALID = 3'd0;
    localparam logic [KEY_TYPE_W-1:0] KT_ESC     = 3'd1;
    localparam logic [KEY_TYPE_W-1:0] KT_PF      = 3'd2;
    localparam logic [KEY_TYPE_W-1:0] KT_CSI     = 3'd3;
    localparam logic [KEY_TYPE_W-1:0] KT_FKEY    = 3'd4;

    localparam logic signed [KEY_VALUE_W-1:0] KEY_NONE = '1;

    localparam logic [7:0] BYTE_CSI_C1    = 8'h9B;
    localparam logic [7:0] ASCII_LBRACKET = 8'h5B;
    localparam logic [7:0] ASCII_O        = 8'h4F;
    localparam logic [7:0] ASCII_SEMI     = 8'h3B;
    localparam logic [7:0] ASCII_TILDE    = 8'h7E;
    localparam logic [7:0] INTER_LO       = 8'h20;
    localparam logic [7:0] INTER_HI       = 8'h2F;
    localparam logic [7:0] PARAM_LO       = 8'h30;
    localparam logic [7:0] PARAM_HI       = 8'h3F;
    localparam logic [7:0] DIGIT_HI       = 8'h39;
    localparam logic [7:0] CSI_FINAL_LO   = 8'h40;
    localparam logic [7:0] FINAL_HI       = 8'h7E;

    localparam logic [PROD_W-1:0] PARAM_LIMIT = PROD_W'(16'hFFFF);

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_ESC_FIRST = 5'b00010,
        PH_ESC_REST  = 5'b00100,
        PH_PF_WAIT   = 5'b01000,
        PH_CSI       = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [CNT_W-1:0]   count;
        logic [PARAM_W-1:0] accum;
        logic               open;
        logic               nonempty;
        logic               bad;
    } t_state;

    typedef struct packed {
        logic                          read_failed;
        logic [KEY_TYPE_W-1:0]         key_type;
        logic signed [KEY_VALUE_W-1:0] key_value;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> hw/rtl/tekp_step.sv
// next-state and result logic for one received byte or event
// depends on tekp_pkg
module tekp_step (
    input  tekp_pkg::t_state  i_state,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_byte,
    output tekp_pkg::t_state  o_state,
    output logic              o_emit,
    output tekp_pkg::t_result o_result
);
    import tekp_pkg::*;

    logic [CNT_W-1:0]  cnt_inc;
    logic [PROD_W-1:0] prod;

    assign cnt_inc = i_state.count + CNT_W'(1);
    assign prod    = ({4'b0, i_state.accum} << 3) + ({4'b0, i_state.accum} << 1)
                   + PROD_W'(i_byte - PARAM_LO);

    always_comb begin
        o_state              = i_state;
        o_emit               = 1'b0;
        o_result.read_failed = 1'b0;
        o_result.key_type    = KT_INVALID;
        o_result.key_value   = KEY_NONE;

        if (i_mode == MODE_START) begin
            o_state.count    = '0;
            o_state.accum    = '0;
            o_state.open     = 1'b1;
            o_state.nonempty = 1'b0;
            o_state.bad      = 1'b0;
            o_state.phase    = (i_byte == BYTE_CSI_C1) ? PH_CSI : PH_ESC_FIRST;
        end else if (i_state.phase != PH_IDLE) begin
            if (i_mode != MODE_NEXT) begin
                o_emit               = 1'b1;
                o_result.read_failed = 1'b1;
                o_result.key_type    = (i_state.phase == PH_PF_WAIT) ? KT_PF : KT_INVALID;
            end else begin
                o_state.count = cnt_inc;
                case (i_state.phase)
                    PH_ESC_FIRST, PH_ESC_REST: begin
                        if (i_state.phase == PH_ESC_FIRST && i_byte == ASCII_LBRACKET) begin
                            o_state.phase = PH_CSI;
                        end else if (i_state.phase == PH_ESC_FIRST && i_byte == ASCII_O) begin
                            o_state.phase = PH_PF_WAIT;
                        end else if (i_byte inside {[PARAM_LO:FINAL_HI]}) begin
                            o_emit             = 1'b1;
                            o_result.key_type  = KT_ESC;
                            o_result.key_value = KEY_VALUE_W'(i_byte);
                        end else if (i_byte inside {[INTER_LO:INTER_HI]}) begin
                            o_state.phase = PH_ESC_REST;
                        end else begin
                            o_emit = 1'b1;
                        end
                    end
                    PH_PF_WAIT: begin
                        o_emit             = 1'b1;
                        o_result.key_type  = KT_PF;
                        o_result.key_value = KEY_VALUE_W'(i_byte);
                    end
                    PH_CSI: begin
                        if (i_byte inside {[CSI_FINAL_LO:FINAL_HI]}) begin
                            o_emit = 1'b1;
                            if (!i_state.nonempty) begin
                                o_result.key_type  = (i_byte == ASCII_TILDE) ? KT_FKEY : KT_CSI;
                                o_result.key_value = KEY_VALUE_W'(i_byte);
                            end else if (!i_state.bad) begin
                                o_result.key_type  = (i_byte == ASCII_TILDE) ? KT_FKEY : KT_CSI;
                                o_result.key_value = KEY_VALUE_W'(i_state.accum);
                            end
                        end else if (i_byte inside {[INTER_LO:INTER_HI]}) begin
                            o_state.open = 1'b0;
                        end else if (i_byte inside {[PARAM_LO:PARAM_HI]}) begin
                            if (i_state.open) begin
                                if (i_byte <= DIGIT_HI) begin
                                    if (prod > PARAM_LIMIT) begin
                                        o_state.accum = '1;
                                        o_state.bad   = 1'b1;
                                    end else begin
                                        o_state.accum = prod[PARAM_W-1:0];
                                    end
                                end else if (i_byte == ASCII_SEMI) begin
                                    if (!i_state.nonempty) begin
                                        o_state.bad = 1'b1;
                                    end
                                    o_state.open = 1'b0;
                                end else begin
                                    o_state.bad = 1'b1;
                                end
                                o_state.nonempty = 1'b1;
                            end
                        end else begin
                            o_emit = 1'b1;
                        end
                    end
                    default: begin
                        o_state.phase = PH_IDLE;
                    end
                endcase
                if (!o_emit && cnt_inc >= CNT_W'(MAX_SEQ_BYTES)) begin
                    o_emit            = 1'b1;
                    o_result.key_type = (o_state.phase == PH_PF_WAIT) ? KT_PF : KT_INVALID;
                end
            end
            if (o_emit) begin
                o_state.phase = PH_IDLE;
            end
        end
    end

endmodule

>>> hw/rtl/tekp_outq.sv
// two-entry result queue in front of the master-side channel
// depends on tekp_pkg
module tekp_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tekp_pkg::t_result   i_data,
    input  logic                i_pop,
    output tekp_pkg::t_result   o_data,
    output tekp_pkg::t_q_status o_status
);
    import tekp_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_pop;
    logic       do_push;

    assign do_pop          = i_pop && (r_count != 2'd0);
    assign do_push         = i_push && (r_count != 2'd2);
    assign o_data          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("result pushed into full queue");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

>>> hw/rtl/terminal_escape_key_parser.sv
// terminal escape key parser: classifies key escape sequences byte by byte
// depends on tekp_pkg, tekp_step and tekp_outq
//
// slave side: one transaction per received byte or event; s_axis_tuser
// carries the mode (start with first byte, next byte, timeout or error)
// and s_axis_tdata the byte. master side: one transaction when a sequence
// ends; m_axis_tdata carries the signed key value, m_axis_tuser the key
// type and the read-failed flag.
// a byte is taken into an input register, classified against the sequence
// state once the result queue is not full, and any result is written into a
// two-entry result queue, from which it is offered on the master side.
// one byte per cycle is sustained while the result queue is not full; the
// state update of one byte feeds the next through a single combinational pass.
// reset clears the sequence state to idle and empties the queue.
// when the receiver stalls, the queue absorbs up to two results, then the
// input register holds its byte and s_axis_tready drops until space frees.
module terminal_escape_key_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // key_value[16:0], zero padding
    output logic [3:0]  m_axis_tuser    // key_type[2:0], read_failed
);
    import tekp_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_in_mode;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    logic       step_emit;
    t_result    step_result;
    t_result    q_data;
    t_q_status  q_status;
    logic       advance;
    logic       in_take;

    assign advance       = r_in_valid && !q_status.full;
    assign s_axis_tready = !r_in_valid || !q_status.full;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_state.phase    <= PH_IDLE;
            r_state.count    <= '0;
            r_state.accum    <= '0;
            r_state.open     <= 1'b0;
            r_state.nonempty <= 1'b0;
            r_state.bad      <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    tekp_step u_step (
        .i_state  (r_state),
        .i_mode   (r_in_mode),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    tekp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (advance && step_emit),
        .i_data   (step_result),
        .i_pop    (m_axis_tready),
        .o_data   (q_data),
        .o_status (q_status)
    );

    assign m_axis_tvalid = !q_status.empty;
    assign m_axis_tdata  = {7'b0, q_data.key_value};
    assign m_axis_tuser  = {q_data.read_failed, q_data.key_type};

`ifndef SYNTH
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && q_status.full) |=> (r_in_valid && $stable(r_in_byte)
            && $stable(r_in_mode)))
        else $error("held input byte lost during stall");

    a_idle_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("sequence state changed without a processed byte");

    a_failed_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |-> (m_axis_tdata[16:0] == KEY_NONE))
        else $error("failed read carries a key value");
`endif

endmodule
